FILE: rtl/tpat_pkg.sv
// Shared types and constants for the tone-pair autotune policy block.
// Depends on nothing; used by tone_pair_autotune_policy.
`default_nettype none

package tpat_pkg;

    localparam int unsigned TIMER_W   = 32;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned MARK_W    = 16;
    localparam int unsigned MARGIN_W  = 11;
    localparam int unsigned BAL_W     = 10;
    localparam int unsigned FLIP_W    = 2;
    localparam int unsigned S_DATA_W  = 72;
    localparam int unsigned M_DATA_W  = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [FLIP_W-1:0] MAX_FLIPS = 2'd2;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_RETUNE = 2'd1,
        ACT_FLIP   = 2'd2
    } action_t;

    typedef enum logic [0:0] {
        FUNC_UPDATE = 1'b0,
        FUNC_CLEAR  = 1'b1
    } func_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LOCK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SEARCH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MARGIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BAL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MOVE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 3'd6;

    localparam logic [MS_W-1:0]            RST_HOLD_LOCK   = 16'd2000;
    localparam logic [MS_W-1:0]            RST_IDLE_SEARCH = 16'd3000;
    localparam logic signed [MARGIN_W-1:0] RST_MIN_MARGIN  = 11'sd60;
    localparam logic [BAL_W-1:0]           RST_MAX_BAL     = 10'd100;
    localparam logic [MARK_W-1:0]          RST_MIN_MOVE    = 16'd100;
    localparam logic [MS_W-1:0]            RST_SETTLE      = 16'd3000;

    typedef struct packed {
        func_t                       func;
        logic [MS_W-1:0]             elapsed_ms;
        logic                        lock_flag;
        logic [MARK_W-1:0]           current_mark;
        logic                        current_reverse;
        logic                        pair_found;
        logic [MARK_W-1:0]           pair_mark;
        logic signed [MARGIN_W-1:0]  pair_margin;
        logic [BAL_W-1:0]            pair_balance;
    } item_t;

    function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
                                                   input logic [MS_W-1:0] b);
        logic [TIMER_W:0] sum;
        sum = {1'b0, a} + {{(TIMER_W + 1 - MS_W){1'b0}}, b};
        return sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tone_pair_autotune_policy.sv
// Top level of the tone-pair autotune policy: input register, decision logic,
// result register and the policy state. Depends on tpat_pkg.
`default_nettype none

// Each update word passes through an input register and a result register. A
// word waits in the input register until the result register is free to take
// its result. One word is taken every cycle while the result side keeps up. The
// policy timers and counters are updated in the same cycle that the result
// register is loaded, which lets the next word use them at once. A clear word
// (tuser high) resets the timers and counters and passes the current settings
// through. Configuration writes are always accepted and should be made while no
// word is in flight.
module tone_pair_autotune_policy (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // elapsed_ms, lock_flag, current_mark, current_reverse, pair_found,
    // pair_mark, pair_margin, pair_balance
    input  wire  [tpat_pkg::S_DATA_W-1:0]      s_tdata,
    // func
    input  wire                                s_tuser,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // changed, action, new_mark, new_reverse, action_margin, one zero pad bit
    output logic [tpat_pkg::M_DATA_W-1:0]      m_tdata,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [tpat_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [tpat_pkg::CFG_DAT_W-1:0]     cfg_data
);

    logic                                   enable_reg;
    logic [tpat_pkg::MS_W-1:0]              hold_lock_reg;
    logic [tpat_pkg::MS_W-1:0]              idle_search_reg;
    logic signed [tpat_pkg::MARGIN_W-1:0]   min_margin_reg;
    logic [tpat_pkg::BAL_W-1:0]             max_bal_reg;
    logic [tpat_pkg::MARK_W-1:0]            min_move_reg;
    logic [tpat_pkg::MS_W-1:0]              settle_reg;

    logic                                   in_valid_reg;
    tpat_pkg::item_t                        in_item_reg;
    logic                                   out_valid_reg;
    logic [tpat_pkg::M_DATA_W-1:0]          out_data_reg;

    logic [tpat_pkg::TIMER_W-1:0]           idle_time_reg, idle_time_next;
    logic [tpat_pkg::TIMER_W-1:0]           since_action_reg, since_action_next;
    logic [tpat_pkg::TIMER_W-1:0]           since_lock_reg, since_lock_next;
    logic [tpat_pkg::FLIP_W-1:0]            flip_count_reg, flip_count_next;
    logic                                   was_locked_reg, was_locked_next;

    logic                                   advance;
    logic                                   process;
    tpat_pkg::action_t                      action;
    logic [tpat_pkg::MARK_W-1:0]            new_mark;
    logic                                   new_reverse;
    logic signed [tpat_pkg::MARGIN_W-1:0]   action_margin;
    logic [tpat_pkg::MARK_W-1:0]            delta;
    logic [tpat_pkg::TIMER_W-1:0]           idle_base;
    logic                                   pair_ok;

    assign advance   = !out_valid_reg || m_tready;
    assign process   = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b1;
            hold_lock_reg   <= tpat_pkg::RST_HOLD_LOCK;
            idle_search_reg <= tpat_pkg::RST_IDLE_SEARCH;
            min_margin_reg  <= tpat_pkg::RST_MIN_MARGIN;
            max_bal_reg     <= tpat_pkg::RST_MAX_BAL;
            min_move_reg    <= tpat_pkg::RST_MIN_MOVE;
            settle_reg      <= tpat_pkg::RST_SETTLE;
        end else if (cfg_valid) begin
            case (cfg_index)
                tpat_pkg::CFG_ENABLE:      enable_reg      <= cfg_data[0];
                tpat_pkg::CFG_HOLD_LOCK:   hold_lock_reg   <= cfg_data;
                tpat_pkg::CFG_IDLE_SEARCH: idle_search_reg <= cfg_data;
                tpat_pkg::CFG_MIN_MARGIN:  min_margin_reg  <= cfg_data[tpat_pkg::MARGIN_W-1:0];
                tpat_pkg::CFG_MAX_BAL:     max_bal_reg     <= cfg_data[tpat_pkg::BAL_W-1:0];
                tpat_pkg::CFG_MIN_MOVE:    min_move_reg    <= cfg_data;
                tpat_pkg::CFG_SETTLE:      settle_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.func            <= tpat_pkg::func_t'(s_tuser);
            in_item_reg.elapsed_ms      <= s_tdata[15:0];
            in_item_reg.lock_flag       <= s_tdata[16];
            in_item_reg.current_mark    <= s_tdata[32:17];
            in_item_reg.current_reverse <= s_tdata[33];
            in_item_reg.pair_found      <= s_tdata[34];
            in_item_reg.pair_mark       <= s_tdata[50:35];
            in_item_reg.pair_margin     <= s_tdata[61:51];
            in_item_reg.pair_balance    <= s_tdata[71:62];
        end
    end

    always_comb begin
        delta = (in_item_reg.pair_mark >= in_item_reg.current_mark) ?
                in_item_reg.pair_mark - in_item_reg.current_mark :
                in_item_reg.current_mark - in_item_reg.pair_mark;
        pair_ok = in_item_reg.pair_found &&
                  (in_item_reg.pair_margin >= min_margin_reg) &&
                  (in_item_reg.pair_balance <= max_bal_reg);
        idle_base = was_locked_reg ? '0 : idle_time_reg;

        action        = tpat_pkg::ACT_NONE;
        new_mark      = in_item_reg.current_mark;
        new_reverse   = in_item_reg.current_reverse;
        action_margin = '0;

        idle_time_next    = idle_time_reg;
        since_action_next = since_action_reg;
        since_lock_next   = since_lock_reg;
        flip_count_next   = flip_count_reg;
        was_locked_next   = was_locked_reg;

        if (in_item_reg.func == tpat_pkg::FUNC_CLEAR) begin
            idle_time_next    = '0;
            since_action_next = '0;
            since_lock_next   = '1;
            flip_count_next   = '0;
            was_locked_next   = 1'b0;
        end else if (enable_reg) begin
            since_action_next = tpat_pkg::sat_add(since_action_reg, in_item_reg.elapsed_ms);
            if (in_item_reg.lock_flag) begin
                idle_time_next  = '0;
                flip_count_next = '0;
                was_locked_next = 1'b1;
                since_lock_next = '0;
            end else begin
                since_lock_next = tpat_pkg::sat_add(since_lock_reg, in_item_reg.elapsed_ms);
                if (since_lock_next >= {16'd0, hold_lock_reg}) begin
                    was_locked_next = 1'b0;
                    idle_time_next  = tpat_pkg::sat_add(idle_base, in_item_reg.elapsed_ms);
                    if (idle_time_next >= {16'd0, idle_search_reg} && pair_ok) begin
                        if (delta >= min_move_reg) begin
                            action            = tpat_pkg::ACT_RETUNE;
                            new_mark          = in_item_reg.pair_mark;
                            action_margin     = in_item_reg.pair_margin;
                            idle_time_next    = '0;
                            since_action_next = '0;
                            flip_count_next   = '0;
                        end else if (since_action_next >= {16'd0, settle_reg} &&
                                     flip_count_reg < tpat_pkg::MAX_FLIPS) begin
                            action            = tpat_pkg::ACT_FLIP;
                            new_reverse       = !in_item_reg.current_reverse;
                            action_margin     = in_item_reg.pair_margin;
                            flip_count_next   = flip_count_reg + 2'd1;
                            since_action_next = '0;
                            idle_time_next    = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_time_reg    <= '0;
            since_action_reg <= '0;
            since_lock_reg   <= '1;
            flip_count_reg   <= '0;
            was_locked_reg   <= 1'b0;
        end else if (process) begin
            idle_time_reg    <= idle_time_next;
            since_action_reg <= since_action_next;
            since_lock_reg   <= since_lock_next;
            flip_count_reg   <= flip_count_next;
            was_locked_reg   <= was_locked_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            out_data_reg <= {1'b0, action_margin, new_reverse, new_mark, action,
                             (action != tpat_pkg::ACT_NONE)};
        end
    end

    a_changed_matches_action: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] != tpat_pkg::ACT_NONE)))
        else $error("changed flag disagrees with action");

    a_no_action_no_margin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:1] == tpat_pkg::ACT_NONE) |-> (m_tdata[30:20] == '0))
        else $error("margin reported without an action");

    a_flip_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        flip_count_reg <= tpat_pkg::MAX_FLIPS)
        else $error("flip count passed its limit");

    a_lock_clears_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && in_item_reg.func == tpat_pkg::FUNC_UPDATE && enable_reg &&
         in_item_reg.lock_flag) |=> (since_lock_reg == '0 && flip_count_reg == '0))
        else $error("lock did not restart the lock timer");

endmodule

`default_nettype wire
